FILE: design/lcvm_pkg.sv
// Shared constants, types and helpers for the line clip and viewport map block.
package lcvm_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_EDGES   = 4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_WIN_X_MIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_Y_MIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_X_MAX  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIN_Y_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_X_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_Y_MIN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_X_MAX = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_Y_MAX = 3'd7;

    localparam int REG_RESET [NUM_REGS] = '{50, 50, 100, 100, 150, 150, 400, 400};

    // Role of one clip edge for a given segment
    typedef enum logic [1:0] {
        EDGE_NONE,
        EDGE_ENTRY,
        EDGE_EXIT
    } t_edge_kind;

    typedef struct packed {
        logic                            rej;
        logic [NUM_EDGES-1:0]            eq;
        t_edge_kind [NUM_EDGES-1:0]      kind;
    } t_ctrl;

    // Width of one classified request in the queue
    function automatic int item_w(input int cw);
        return 2 * cw + 10 * (cw + 1) + $bits(t_ctrl);
    endfunction

endpackage

FILE: design/lcvm_ifs.sv
// Channel interfaces: segment input, result output and register write port.
interface lcvm_seg_if #(parameter int W = lcvm_pkg::COORD_WIDTH);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lcvm_res_if #(parameter int W = lcvm_pkg::COORD_WIDTH);
    logic                valid;
    logic                ready;
    logic                visible;
    logic signed [W-1:0] out_start_x;
    logic signed [W-1:0] out_start_y;
    logic signed [W-1:0] out_end_x;
    logic signed [W-1:0] out_end_y;
    modport source (output valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                    input ready);
    modport sink   (input valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                    output ready);
endinterface

interface lcvm_cfg_if #(parameter int W = lcvm_pkg::COORD_WIDTH);
    logic                              valid;
    logic                              ready;
    logic [lcvm_pkg::REG_IDX_W-1:0]    idx;
    logic [W-1:0]                      data;
    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

FILE: design/lcvm_divpipe.sv
// Pipelined restoring divider: one quotient bit per stage.
module lcvm_divpipe #(
    parameter int DW = lcvm_pkg::COORD_WIDTH + 1,
    parameter int NB = lcvm_pkg::FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    input  logic [NB-1:0] i_bits,
    output logic [NB-1:0] o_quo
);

    logic [DW-1:0] r_rem  [NB];
    logic [DW-1:0] r_div  [NB];
    logic [NB-1:0] r_bits [NB];
    logic [NB-1:0] r_quo  [NB];
    logic [DW-1:0] n_rem  [NB];
    logic [NB-1:0] n_bits [NB];
    logic [NB-1:0] n_quo  [NB];

    // One shift-compare-subtract per stage; remainder stays below the divisor
    always_comb begin
        logic [DW-1:0] rem_in;
        logic [DW-1:0] div_in;
        logic [NB-1:0] bits_in;
        logic [NB-1:0] quo_in;
        logic [DW:0]   sh;
        logic          ge;
        for (int k = 0; k < NB; k++) begin
            if (k == 0) begin
                rem_in  = i_rem;
                div_in  = i_div;
                bits_in = i_bits;
                quo_in  = '0;
            end else begin
                rem_in  = r_rem[k-1];
                div_in  = r_div[k-1];
                bits_in = r_bits[k-1];
                quo_in  = r_quo[k-1];
            end
            sh        = {rem_in, bits_in[NB-1]};
            ge        = (sh >= {1'b0, div_in});
            n_rem[k]  = ge ? DW'(sh - {1'b0, div_in}) : DW'(sh);
            n_bits[k] = bits_in << 1;
            n_quo[k]  = {quo_in[NB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NB; k++) begin
                r_rem[k]  <= n_rem[k];
                r_bits[k] <= n_bits[k];
                r_quo[k]  <= n_quo[k];
                r_div[k]  <= (k == 0) ? i_div : r_div[k-1];
            end
        end
    end

    assign o_quo = r_quo[NB-1];

endmodule

FILE: design/lcvm_front.sv
// Front end: takes a segment, runs the edge classification, registers the request.
module lcvm_front #(
    parameter int CW = lcvm_pkg::COORD_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lcvm_seg_if.sink                         i_seg,
    input  logic signed [CW-1:0]             i_win [4],
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lcvm_pkg::item_w(CW)-1:0]  o_data
);

    localparam int NE = lcvm_pkg::NUM_EDGES;

    logic signed [CW:0] dx, dy;
    logic signed [CW:0] p [NE];
    logic signed [CW:0] q [NE];
    lcvm_pkg::t_ctrl    ctrl;
    logic [NE-1:0][CW:0] num, den;

    logic                r_valid;
    lcvm_pkg::t_ctrl     r_ctrl;
    logic signed [CW-1:0] r_x0, r_y0;
    logic signed [CW:0]  r_dx, r_dy;
    logic [NE-1:0][CW:0] r_num, r_den;

    logic accept;

    assign accept      = i_seg.valid && i_seg.ready;
    assign i_seg.ready = !r_valid || i_ready;

    // Edge terms in order left, right, bottom, top
    always_comb begin
        dx   = $signed({i_seg.end_x[CW-1], i_seg.end_x}) -
               $signed({i_seg.start_x[CW-1], i_seg.start_x});
        dy   = $signed({i_seg.end_y[CW-1], i_seg.end_y}) -
               $signed({i_seg.start_y[CW-1], i_seg.start_y});
        p[0] = -dx;
        q[0] = $signed({i_seg.start_x[CW-1], i_seg.start_x}) - $signed({i_win[0][CW-1], i_win[0]});
        p[1] = dx;
        q[1] = $signed({i_win[2][CW-1], i_win[2]}) - $signed({i_seg.start_x[CW-1], i_seg.start_x});
        p[2] = -dy;
        q[2] = $signed({i_seg.start_y[CW-1], i_seg.start_y}) - $signed({i_win[1][CW-1], i_win[1]});
        p[3] = dy;
        q[3] = $signed({i_win[3][CW-1], i_win[3]}) - $signed({i_seg.start_y[CW-1], i_seg.start_y});
    end

    // Classify each edge: trivial, entry, exit or reject; set up the divider operands
    always_comb begin
        logic signed [CW:0] nn;
        logic signed [CW:0] dd;
        ctrl.rej = (i_win[2] <= i_win[0]) || (i_win[3] <= i_win[1]);
        for (int e = 0; e < NE; e++) begin
            ctrl.kind[e] = lcvm_pkg::EDGE_NONE;
            ctrl.eq[e]   = 1'b0;
            num[e]       = '0;
            den[e]       = (CW+1)'(1);
            nn           = -q[e];
            dd           = -p[e];
            if (p[e] == '0) begin
                if (q[e] < 0) ctrl.rej = 1'b1;
            end else if (p[e] < 0) begin
                if (nn <= 0) begin
                    ctrl.kind[e] = lcvm_pkg::EDGE_NONE;
                end else if (nn > dd) begin
                    ctrl.rej = 1'b1;
                end else begin
                    ctrl.kind[e] = lcvm_pkg::EDGE_ENTRY;
                    if (nn == dd) begin
                        ctrl.eq[e] = 1'b1;
                    end else begin
                        num[e] = nn;
                        den[e] = dd;
                    end
                end
            end else begin
                if (q[e] < 0) begin
                    ctrl.rej = 1'b1;
                end else if (q[e] < p[e]) begin
                    ctrl.kind[e] = lcvm_pkg::EDGE_EXIT;
                    num[e]       = q[e];
                    den[e]       = p[e];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_seg.ready) begin
            r_valid <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctrl <= ctrl;
            r_x0   <= i_seg.start_x;
            r_y0   <= i_seg.start_y;
            r_dx   <= dx;
            r_dy   <= dy;
            r_num  <= num;
            r_den  <= den;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_ctrl, r_x0, r_y0, r_dx, r_dy, r_num, r_den};

endmodule

FILE: design/lcvm_fifo.sv
// Small request queue between the front and back ends.
module lcvm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = lcvm_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: design/lcvm_back.sv
// Back end: t division, clipped point, viewport scaling, rounding and saturation.
module lcvm_back #(
    parameter int CW = lcvm_pkg::COORD_WIDTH,
    parameter int FB = lcvm_pkg::FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lcvm_pkg::item_w(CW)-1:0]  i_data,
    input  logic signed [CW-1:0]             i_regs [lcvm_pkg::NUM_REGS],
    lcvm_res_if.source                       o_res
);

    localparam int NE = lcvm_pkg::NUM_EDGES;
    localparam int DW = CW + 1;
    localparam int AW = CW + FB + 4;
    localparam int PW = AW + CW + 1;
    localparam int YW = PW + 1 - FB;
    localparam int NB = CW + 2;
    localparam int TW = FB + 1;

    logic en;

    // Request fields
    lcvm_pkg::t_ctrl      in_ctrl;
    logic signed [CW-1:0] in_x0, in_y0;
    logic signed [CW:0]   in_dx, in_dy;
    logic [NE-1:0][CW:0]  in_num, in_den;

    assign {in_ctrl, in_x0, in_y0, in_dx, in_dy, in_num, in_den} = i_data;

    // Config views
    logic signed [CW-1:0] wmin [2], wmax [2], vmin [2], vmax [2];
    assign wmin[0] = i_regs[lcvm_pkg::REG_WIN_X_MIN];
    assign wmin[1] = i_regs[lcvm_pkg::REG_WIN_Y_MIN];
    assign wmax[0] = i_regs[lcvm_pkg::REG_WIN_X_MAX];
    assign wmax[1] = i_regs[lcvm_pkg::REG_WIN_Y_MAX];
    assign vmin[0] = i_regs[lcvm_pkg::REG_VIEW_X_MIN];
    assign vmin[1] = i_regs[lcvm_pkg::REG_VIEW_Y_MIN];
    assign vmax[0] = i_regs[lcvm_pkg::REG_VIEW_X_MAX];
    assign vmax[1] = i_regs[lcvm_pkg::REG_VIEW_Y_MAX];

    logic [DW-1:0] win_w [2];
    assign win_w[0] = DW'($signed({wmax[0][CW-1], wmax[0]}) - $signed({wmin[0][CW-1], wmin[0]}));
    assign win_w[1] = DW'($signed({wmax[1][CW-1], wmax[1]}) - $signed({wmin[1][CW-1], wmin[1]}));

    // ---------------- t division, one per edge ----------------
    logic [FB-1:0] t_quo [NE];

    for (genvar e = 0; e < NE; e++) begin : g_tdiv
        lcvm_divpipe #(.DW(DW), .NB(FB)) u_tdiv (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (in_num[e]),
            .i_div  (in_den[e]),
            .i_bits ('0),
            .o_quo  (t_quo[e])
        );
    end

    // Side band alongside the t dividers
    logic                 r_t_v    [FB];
    lcvm_pkg::t_ctrl      r_t_ctrl [FB];
    logic signed [CW-1:0] r_t_x0   [FB];
    logic signed [CW-1:0] r_t_y0   [FB];
    logic signed [CW:0]   r_t_dx   [FB];
    logic signed [CW:0]   r_t_dy   [FB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FB; k++) r_t_v[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < FB; k++) r_t_v[k] <= (k == 0) ? i_valid : r_t_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < FB; k++) begin
                r_t_ctrl[k] <= (k == 0) ? in_ctrl : r_t_ctrl[k-1];
                r_t_x0[k]   <= (k == 0) ? in_x0   : r_t_x0[k-1];
                r_t_y0[k]   <= (k == 0) ? in_y0   : r_t_y0[k-1];
                r_t_dx[k]   <= (k == 0) ? in_dx   : r_t_dx[k-1];
                r_t_dy[k]   <= (k == 0) ? in_dy   : r_t_dy[k-1];
            end
        end
    end

    // ---------------- stage A: entry max, exit min, visibility ----------------
    logic [TW-1:0] te, tl;
    logic          vis;

    always_comb begin
        logic [TW-1:0] t;
        te = '0;
        tl = {1'b1, {FB{1'b0}}};
        for (int e = 0; e < NE; e++) begin
            t = r_t_ctrl[FB-1].eq[e] ? {1'b1, {FB{1'b0}}} : {1'b0, t_quo[e]};
            unique case (r_t_ctrl[FB-1].kind[e])
                lcvm_pkg::EDGE_ENTRY: if (t > te) te = t;
                lcvm_pkg::EDGE_EXIT:  if (t < tl) tl = t;
                default: ;
            endcase
        end
        vis = !r_t_ctrl[FB-1].rej && (te <= tl);
    end

    logic                 r_a_v, r_a_vis;
    logic [TW-1:0]        r_a_te, r_a_tl;
    logic signed [CW-1:0] r_a_x0, r_a_y0;
    logic signed [CW:0]   r_a_dx, r_a_dy;

    // ---------------- stage C: clipped points relative to window corner ----------------
    logic signed [AW-1:0] a_val [NE];

    always_comb begin
        logic signed [AW-1:0]     diff;
        logic signed [FB+CW+2:0]  mprod;
        logic [TW-1:0]            t;
        logic signed [CW:0]       d;
        logic signed [CW-1:0]     p0;
        logic signed [CW-1:0]     wm;
        for (int c = 0; c < NE; c++) begin
            t        = (c < 2) ? r_a_te : r_a_tl;
            d        = (c % 2 == 1) ? r_a_dy : r_a_dx;
            p0       = (c % 2 == 1) ? r_a_y0 : r_a_x0;
            wm       = wmin[c % 2];
            diff     = AW'(p0) - AW'(wm);
            mprod    = $signed({1'b0, t}) * d;
            a_val[c] = (diff <<< FB) + AW'(mprod);
        end
    end

    logic                 r_c_v, r_c_vis;
    logic signed [AW-1:0] r_c_a [NE];

    // ---------------- stage D: magnitude product with viewport span ----------------
    logic [PW-1:0] prod [NE];
    logic [NE-1:0] neg;

    always_comb begin
        logic [AW-1:0]      ua;
        logic signed [CW:0] b;
        logic [CW:0]        ub;
        for (int c = 0; c < NE; c++) begin
            ua      = r_c_a[c][AW-1] ? AW'(-r_c_a[c]) : AW'(r_c_a[c]);
            b       = $signed({vmax[c % 2][CW-1], vmax[c % 2]}) -
                      $signed({vmin[c % 2][CW-1], vmin[c % 2]});
            ub      = b[CW] ? (CW+1)'(-b) : (CW+1)'(b);
            prod[c] = PW'(ua) * PW'(ub);
            neg[c]  = r_c_a[c][AW-1] ^ b[CW];
        end
    end

    logic                 r_d_v, r_d_vis;
    logic [PW-1:0]        r_d_prod [NE];
    logic [NE-1:0]        r_d_neg;

    // ---------------- stage E: add half, drop fraction, overflow check ----------------
    logic [DW-1:0] e_rem [NE];
    logic [NB-1:0] e_lo  [NE];
    logic [NE-1:0] e_sat;

    always_comb begin
        logic [PW:0]    sum;
        logic [YW-1:0]  y;
        logic [YW-NB-1:0] hi;
        for (int c = 0; c < NE; c++) begin
            sum      = (PW+1)'(r_d_prod[c]) + ((PW+1)'(win_w[c % 2]) << (FB - 1));
            y        = sum[PW:FB];
            hi       = y[YW-1:NB];
            e_sat[c] = (hi >= (YW-NB)'(win_w[c % 2]));
            e_rem[c] = e_sat[c] ? '0 : DW'(hi);
            e_lo[c]  = y[NB-1:0];
        end
    end

    logic                 r_e_v, r_e_vis;
    logic [DW-1:0]        r_e_rem [NE];
    logic [NB-1:0]        r_e_lo  [NE];
    logic [NE-1:0]        r_e_sat, r_e_neg;

    // Registers for stages A, C, D, E
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (en) begin
            r_a_v <= r_t_v[FB-1];
            r_c_v <= r_a_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_vis <= vis;
            r_a_te  <= te;
            r_a_tl  <= tl;
            r_a_x0  <= r_t_x0[FB-1];
            r_a_y0  <= r_t_y0[FB-1];
            r_a_dx  <= r_t_dx[FB-1];
            r_a_dy  <= r_t_dy[FB-1];
            r_c_vis <= r_a_vis;
            r_d_vis <= r_c_vis;
            r_e_vis <= r_d_vis;
            r_d_neg <= neg;
            r_e_neg <= r_d_neg;
            r_e_sat <= e_sat;
            for (int c = 0; c < NE; c++) begin
                r_c_a[c]    <= a_val[c];
                r_d_prod[c] <= prod[c];
                r_e_rem[c]  <= e_rem[c];
                r_e_lo[c]   <= e_lo[c];
            end
        end
    end

    // ---------------- viewport division by window width ----------------
    logic [NB-1:0] m_quo [NE];

    for (genvar c = 0; c < NE; c++) begin : g_mdiv
        lcvm_divpipe #(.DW(DW), .NB(NB)) u_mdiv (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (r_e_rem[c]),
            .i_div  (win_w[c % 2]),
            .i_bits (r_e_lo[c]),
            .o_quo  (m_quo[c])
        );
    end

    logic          r_m_v   [NB];
    logic          r_m_vis [NB];
    logic [NE-1:0] r_m_neg [NB];
    logic [NE-1:0] r_m_sat [NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NB; k++) r_m_v[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < NB; k++) r_m_v[k] <= (k == 0) ? r_e_v : r_m_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NB; k++) begin
                r_m_vis[k] <= (k == 0) ? r_e_vis : r_m_vis[k-1];
                r_m_neg[k] <= (k == 0) ? r_e_neg : r_m_neg[k-1];
                r_m_sat[k] <= (k == 0) ? r_e_sat : r_m_sat[k-1];
            end
        end
    end

    // ---------------- stage F: cap, offset by viewport min, saturate ----------------
    logic [CW-1:0] res [NE];

    always_comb begin
        logic [NB-1:0]         cap;
        logic [NB-1:0]         qv;
        logic signed [CW+2:0]  base;
        logic signed [CW+2:0]  sres;
        logic signed [CW+2:0]  hi_lim;
        logic signed [CW+2:0]  lo_lim;
        cap    = NB'(1) << (CW + 1);
        hi_lim = $signed({4'b0000, {(CW-1){1'b1}}});
        lo_lim = $signed({4'b1111, {(CW-1){1'b0}}});
        for (int c = 0; c < NE; c++) begin
            qv   = (r_m_sat[NB-1][c] || (m_quo[c] > cap)) ? cap : m_quo[c];
            base = (CW+3)'(vmin[c % 2]);
            sres = r_m_neg[NB-1][c] ? base - $signed({1'b0, qv}) : base + $signed({1'b0, qv});
            if (sres > hi_lim) sres = hi_lim;
            if (sres < lo_lim) sres = lo_lim;
            res[c] = sres[CW-1:0];
        end
    end

    // Output register
    logic                 r_out_v, r_out_vis;
    logic signed [CW-1:0] r_out_c [NE];

    assign en      = !r_out_v || o_res.ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_m_v[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_vis <= r_m_vis[NB-1];
            for (int c = 0; c < NE; c++) begin
                r_out_c[c] <= r_m_vis[NB-1] ? res[c] : '0;
            end
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.visible     = r_out_vis;
    assign o_res.out_start_x = r_out_c[0];
    assign o_res.out_start_y = r_out_c[1];
    assign o_res.out_end_x   = r_out_c[2];
    assign o_res.out_end_y   = r_out_c[3];

endmodule

FILE: design/line_clip_viewport_map_top.sv
// Throughput: one segment per cycle while the output is not stalled; the t and viewport
// dividers are pipelined one quotient bit per stage, and a four-entry queue separates
// front and back.
// Reset: synchronous active-low i_rst_n empties the pipeline and queue and loads the
// window (50,50)-(100,100) and viewport (150,150)-(400,400).
module line_clip_viewport_map_top #(
    parameter int COORD_WIDTH = lcvm_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = lcvm_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcvm_seg_if.sink    i_seg,
    lcvm_cfg_if.sink    i_cfg,
    lcvm_res_if.source  o_res
);

    localparam int IW = lcvm_pkg::item_w(COORD_WIDTH);

    // Configuration registers
    logic signed [COORD_WIDTH-1:0] r_regs [lcvm_pkg::NUM_REGS];
    logic signed [COORD_WIDTH-1:0] win [4];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lcvm_pkg::NUM_REGS; k++) begin
                r_regs[k] <= COORD_WIDTH'(lcvm_pkg::REG_RESET[k]);
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_regs[i_cfg.idx] <= i_cfg.data;
        end
    end

    assign win[0] = r_regs[lcvm_pkg::REG_WIN_X_MIN];
    assign win[1] = r_regs[lcvm_pkg::REG_WIN_Y_MIN];
    assign win[2] = r_regs[lcvm_pkg::REG_WIN_X_MAX];
    assign win[3] = r_regs[lcvm_pkg::REG_WIN_Y_MAX];

    logic          front_v, fifo_rdy, q_v, back_rdy;
    logic [IW-1:0] front_data, q_data;

    lcvm_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_win   (win),
        .o_valid (front_v),
        .i_ready (fifo_rdy),
        .o_data  (front_data)
    );

    lcvm_fifo #(.W(IW), .DEPTH(lcvm_pkg::QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .o_ready (fifo_rdy),
        .i_data  (front_data),
        .o_valid (q_v),
        .i_ready (back_rdy),
        .o_data  (q_data)
    );

    lcvm_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_v),
        .o_ready (back_rdy),
        .i_data  (q_data),
        .i_regs  (r_regs),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    // A stalled result freezes the back end: no request leaves the queue
    a_stall_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !back_rdy)
        else $error("back end took a request while its output was stalled");

    // An invisible result carries zero coordinates
    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.visible) |->
        (o_res.out_start_x == '0 && o_res.out_start_y == '0 &&
         o_res.out_end_x == '0 && o_res.out_end_y == '0))
        else $error("invisible result with nonzero coordinates");

    // A classified request waiting on a full queue is not dropped
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_v && !fifo_rdy) |=> front_v)
        else $error("front request lost while queue was full");
`endif

endmodule
